>>> sv/ors_pkg.sv
// Shared types and constants for the 1-Wire Search ROM engine.
`default_nettype none

package ors_pkg;

    // Default ROM code length in bits
    localparam int ROM_BITS_DEF = 64;
    // Fixed port widths
    localparam int ROM_ID_W = 64;
    localparam int COUNT_W  = 8;
    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    // Reset value of the device limit register
    localparam logic [COUNT_W-1:0] MAX_DEVICES_RST = 8'd8;

    // Configuration register word indexes
    typedef enum logic [0:0] {
        REG_MAX_DEVICES = 1'b0
    } reg_idx_t;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_PRESENCE = 2'd1,
        OP_BITS     = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_BIT     = 3'd0,
        ST_MORE    = 3'd1,
        ST_LAST    = 3'd2,
        ST_NOPRES  = 3'd3,
        ST_DATAERR = 3'd4,
        ST_CMD     = 3'd5,
        ST_STARTED = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0] op;
        logic       presence_seen;
        logic       id_bit;
        logic       cmp_bit;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic                 write_bit;
        logic [ROM_ID_W-1:0]  rom_id;
        logic [COUNT_W-1:0]   device_count;
    } result_t;

endpackage

`default_nettype wire

>>> sv/ors_cfg.sv
// APB register block holding the device limit.
`default_nettype none

module ors_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ors_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ors_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [ors_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic      [ors_pkg::COUNT_W-1:0]     max_devices
);
    import ors_pkg::*;

    logic [COUNT_W-1:0] max_dev_reg;
    logic               word_hit;
    logic               wr_en;

    // Word decode: byte lanes inside a word select nothing
    assign word_hit = (paddr[APB_ADDR_W-1] == REG_MAX_DEVICES);
    assign wr_en    = psel && penable && pwrite && word_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dev_reg <= MAX_DEVICES_RST;
        end
        else if (wr_en)
        begin
            max_dev_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        if (word_hit)
        begin
            prdata = APB_DATA_W'(max_dev_reg);
        end
    end

    assign pready      = 1'b1;
    assign max_devices = max_dev_reg;

endmodule

`default_nettype wire

>>> sv/ors_core.sv
// Search state registers and the combinational step of the ROM tree walk.
`default_nettype none

module ors_core #(
    parameter int ROM_BITS = ors_pkg::ROM_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire ors_pkg::item_t               item,
    input  wire logic [ors_pkg::COUNT_W-1:0]  max_devices,
    output logic                              res_valid,
    output ors_pkg::result_t                  res
);
    import ors_pkg::*;

    // Positions run from ROM_BITS+1 (search first) down to 0
    localparam int POS_W = $clog2(ROM_BITS + 2);
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(ROM_BITS + 1);
    localparam logic [POS_W-1:0] POS_FULL  = POS_W'(ROM_BITS);

    logic [ROM_BITS-1:0] rom_shift_reg, rom_shift_next;
    logic [POS_W-1:0]    last_disc_reg, last_disc_next;
    logic [POS_W-1:0]    new_disc_reg,  new_disc_next;
    logic [POS_W-1:0]    bit_pos_reg,   bit_pos_next;
    logic [COUNT_W-1:0]  found_reg,     found_next;
    logic                searching_reg, searching_next;

    logic                both_zero;
    logic                take_one;
    logic                dir_bit;
    logic [POS_W-1:0]    pos_dec;
    logic [POS_W-1:0]    disc_upd;
    logic [ROM_BITS-1:0] shifted;
    logic [COUNT_W-1:0]  found_inc;
    logic                last_dev;

    // Branch choice at the current position
    assign both_zero = !item.id_bit && !item.cmp_bit;
    assign take_one  = (last_disc_reg > bit_pos_reg)
                    || (rom_shift_reg[0] && (last_disc_reg != bit_pos_reg));
    assign dir_bit   = item.id_bit || (both_zero && take_one);
    assign disc_upd  = (both_zero && take_one) ? bit_pos_reg : new_disc_reg;
    assign pos_dec   = bit_pos_reg - POS_W'(1);
    assign shifted   = {dir_bit, rom_shift_reg[ROM_BITS-1:1]};
    assign found_inc = found_reg + COUNT_W'(1);
    assign last_dev  = (disc_upd == '0) || (found_inc >= max_devices);

    // Next state and result
    always_comb
    begin
        rom_shift_next = rom_shift_reg;
        last_disc_next = last_disc_reg;
        new_disc_next  = new_disc_reg;
        bit_pos_next   = bit_pos_reg;
        found_next     = found_reg;
        searching_next = searching_reg;
        res_valid      = 1'b0;
        res.status     = ST_BIT;
        res.write_bit  = 1'b0;
        res.rom_id     = '0;
        if (fire)
        begin
            unique case (item.op)
                OP_START:
                begin
                    found_next     = '0;
                    last_disc_next = POS_FIRST;
                    new_disc_next  = '0;
                    rom_shift_next = '0;
                    bit_pos_next   = '0;
                    searching_next = (max_devices != '0);
                    res_valid      = 1'b1;
                    res.status     = ST_STARTED;
                end
                OP_PRESENCE:
                begin
                    if (searching_reg)
                    begin
                        res_valid = 1'b1;
                        if (!item.presence_seen)
                        begin
                            searching_next = 1'b0;
                            bit_pos_next   = '0;
                            res.status     = ST_NOPRES;
                        end
                        else
                        begin
                            bit_pos_next  = POS_FULL;
                            new_disc_next = '0;
                            res.status    = ST_CMD;
                        end
                    end
                end
                OP_BITS:
                begin
                    if (searching_reg && (bit_pos_reg != '0))
                    begin
                        res_valid = 1'b1;
                        if (item.id_bit && item.cmp_bit)
                        begin
                            searching_next = 1'b0;
                            bit_pos_next   = '0;
                            res.status     = ST_DATAERR;
                        end
                        else
                        begin
                            rom_shift_next = shifted;
                            new_disc_next  = disc_upd;
                            bit_pos_next   = pos_dec;
                            res.write_bit  = dir_bit;
                            if (pos_dec != '0)
                            begin
                                res.status = ST_BIT;
                            end
                            else
                            begin
                                // Last bit of the pass: a device is found
                                found_next     = found_inc;
                                last_disc_next = disc_upd;
                                res.rom_id     = ROM_ID_W'(shifted);
                                if (last_dev)
                                begin
                                    searching_next = 1'b0;
                                    res.status     = ST_LAST;
                                end
                                else
                                begin
                                    res.status = ST_MORE;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.device_count = found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_shift_reg <= '0;
            last_disc_reg <= POS_FIRST;
            new_disc_reg  <= '0;
            bit_pos_reg   <= POS_FULL;
            found_reg     <= '0;
            searching_reg <= 1'b0;
        end
        else
        begin
            rom_shift_reg <= rom_shift_next;
            last_disc_reg <= last_disc_next;
            new_disc_reg  <= new_disc_next;
            bit_pos_reg   <= bit_pos_next;
            found_reg     <= found_next;
            searching_reg <= searching_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/onewire_rom_search_engine.sv
// Top level of the 1-Wire Search ROM engine: input register, step core, result register.
`default_nettype none

// Walks the 1-Wire Search ROM tree one bus event per transaction. Each input
// transaction is captured in an input register; when the result register is
// free or draining, a single combinational step updates the search state and
// loads the result register, so one transaction is taken every cycle as long
// as the result side does not stall. Transactions that cause no result
// (presence while idle, bit pairs outside a pass, unknown op) pass through the
// step without output. The device limit is the only register, at byte address
// 0 of the APB port, and should be written while no transaction is in flight.
module onewire_rom_search_engine #(
    parameter int ROM_BITS = ors_pkg::ROM_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      op,
    input  wire logic                            presence_seen,
    input  wire logic                            id_bit,
    input  wire logic                            cmp_bit,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [2:0]                      status,
    output logic                                 write_bit,
    output logic      [ors_pkg::ROM_ID_W-1:0]    rom_id,
    output logic      [ors_pkg::COUNT_W-1:0]     device_count,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ors_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ors_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [ors_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import ors_pkg::*;

    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    logic               advance;
    logic               res_valid;
    result_t            res;
    logic [COUNT_W-1:0] max_devices;

    // Register block
    ors_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_devices (max_devices)
    );

    // Held item moves on when the result register is free or draining
    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg.op            <= op;
            in_item_reg.presence_seen <= presence_seen;
            in_item_reg.id_bit        <= id_bit;
            in_item_reg.cmp_bit       <= cmp_bit;
        end
    end

    // Search step
    ors_core #(
        .ROM_BITS (ROM_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .item        (in_item_reg),
        .max_devices (max_devices),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign write_bit    = out_res_reg.write_bit;
    assign rom_id       = out_res_reg.rom_id;
    assign device_count = out_res_reg.device_count;

endmodule

`default_nettype wire

>>> sv/ors_chk.sv
// Port-level assertion checker for the 1-Wire Search ROM engine, with its bind.
`default_nettype none

module ors_chk (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_stall,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [2:0]                   status,
    input wire logic                         write_bit,
    input wire logic [ors_pkg::ROM_ID_W-1:0] rom_id,
    input wire logic [ors_pkg::COUNT_W-1:0]  device_count
);
    import ors_pkg::*;

    // Input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)
            && $stable(write_bit) && $stable(rom_id) && $stable(device_count)))
        else $error("stalled result changed");

    // ROM code only travels with a found device
    a_rom_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_MORE) && (status != ST_LAST)) |-> (rom_id == '0))
        else $error("rom_id nonzero outside a found result");

    // Direction bit only with a bit or found result
    a_wbit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_bit) |->
            ((status == ST_BIT) || (status == ST_MORE) || (status == ST_LAST)))
        else $error("write_bit set on a status without a direction");

    // Start clears the device count
    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_STARTED)) |-> (device_count == '0))
        else $error("device count not cleared on start");

endmodule

bind onewire_rom_search_engine ors_chk u_ors_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .write_bit    (write_bit),
    .rom_id       (rom_id),
    .device_count (device_count)
);

`default_nettype wire

>>> bench/tb_onewire_rom_search_engine.sv
// Self-checking testbench for the 1-Wire Search ROM engine, driven by a simulated device bus.
module tb_onewire_rom_search_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ors_pkg::*;

    // Predicts the search engine's results and checks them in order
    class rom_search_checker;
        // predicted search state
        logic [ROM_ID_W-1:0] rom_sr;
        logic [6:0]          last_disc;
        logic [6:0]          new_disc;
        logic [6:0]          bits_left;
        logic [COUNT_W-1:0]  found;
        logic [COUNT_W-1:0]  dev_limit;
        bit                  active;
        logic                last_wb;
        // results still owed by the block
        result_t             pending[$];
        int                  checked;
        int                  mismatches;
        int                  ids_reported;

        function void power_on();
            rom_sr       = '0;
            last_disc    = 7'(ROM_BITS_DEF + 1);
            new_disc     = '0;
            bits_left    = 7'(ROM_BITS_DEF);
            found        = '0;
            dev_limit    = MAX_DEVICES_RST;
            active       = 1'b0;
            last_wb      = 1'b0;
            checked      = 0;
            mismatches   = 0;
            ids_reported = 0;
            pending.delete();
        endfunction

        function void set_limit(logic [COUNT_W-1:0] v);
            dev_limit = v;
        endfunction

        // Advance the predicted search by one accepted transaction; 1 if it yields a result
        function bit note_input(item_t it);
            result_t    r;
            logic       dir;
            logic [6:0] pos;
            r   = '0;
            dir = 1'b0;
            pos = bits_left;
            case (it.op)
                OP_START: begin
                    found     = '0;
                    last_disc = 7'(ROM_BITS_DEF + 1);
                    new_disc  = '0;
                    rom_sr    = '0;
                    bits_left = '0;
                    active    = (dev_limit != 0);
                    r.status  = ST_STARTED;
                end
                OP_PRESENCE: begin
                    if (!active)
                        return 1'b0;
                    if (!it.presence_seen) begin
                        active    = 1'b0;
                        bits_left = '0;
                        r.status  = ST_NOPRES;
                    end
                    else begin
                        bits_left = 7'(ROM_BITS_DEF);
                        new_disc  = '0;
                        r.status  = ST_CMD;
                    end
                end
                OP_BITS: begin
                    if (!active || pos == 0)
                        return 1'b0;
                    if (it.id_bit && it.cmp_bit) begin
                        active    = 1'b0;
                        bits_left = '0;
                        r.status  = ST_DATAERR;
                    end
                    else begin
                        dir = it.id_bit;
                        // both bits 0: devices disagree here, pick the branch
                        if (!it.id_bit && !it.cmp_bit &&
                            (last_disc > pos || (rom_sr[0] && last_disc != pos))) begin
                            dir      = 1'b1;
                            new_disc = pos;
                        end
                        rom_sr      = {dir, rom_sr[ROM_ID_W-1:1]};
                        bits_left   = pos - 7'd1;
                        r.write_bit = dir;
                        if (bits_left != 0)
                            r.status = ST_BIT;
                        else begin
                            found     = found + 1'b1;
                            last_disc = new_disc;
                            r.rom_id  = rom_sr;
                            ids_reported++;
                            if (last_disc == 0 || found >= dev_limit) begin
                                active   = 1'b0;
                                r.status = ST_LAST;
                            end
                            else
                                r.status = ST_MORE;
                        end
                    end
                end
                default: return 1'b0;
            endcase
            r.device_count = found;
            last_wb = r.write_bit;
            pending.push_back(r);
            return 1'b1;
        endfunction

        // Compare one result transaction against the oldest prediction
        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d wb %0b id %h count %0d",
                             got.status, got.write_bit, got.rom_id, got.device_count);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status !== want.status || got.write_bit !== want.write_bit ||
                got.rom_id !== want.rom_id || got.device_count !== want.device_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d: expected st %0d wb %0b id %h cnt %0d,",
                             checked, want.status, want.write_bit, want.rom_id,
                             want.device_count,
                             " got st %0d wb %0b id %h cnt %0d",
                             got.status, got.write_bit, got.rom_id, got.device_count);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 4;
    localparam int NPHASE      = 7;
    localparam int MAX_BUS_DEV = 8;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [1:0]            op            = '0;
    logic                  presence_seen = 1'b0;
    logic                  id_bit        = 1'b0;
    logic                  cmp_bit       = 1'b0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [2:0]            status;
    logic                  write_bit;
    logic [ROM_ID_W-1:0]   rom_id;
    logic [COUNT_W-1:0]    device_count;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rom_search_checker chk;
    int  cycles = 0;
    int  productive;
    int  searches;
    int  cfg_errors;
    bit  item_produced;
    bit  no_idle;

    // simulated devices on the bus
    logic [ROM_ID_W-1:0] bus_ids[MAX_BUS_DEV];
    bit                  bus_alive[MAX_BUS_DEV];

    onewire_rom_search_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .presence_seen (presence_seen),
        .id_bit        (id_bit),
        .cmp_bit       (cmp_bit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .write_bit     (write_bit),
        .rom_id        (rom_id),
        .device_count  (device_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, chk.pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    // result side: random stall before each transaction
    initial
    begin : result_stall
        int n;
        forever
        begin
            n = draw_wait();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got.status       = status_t'(status);
            got.write_bit    = write_bit;
            got.rom_id       = rom_id;
            got.device_count = device_count;
            chk.check_result(got);
        end
    end

    // Present one input transaction after a random gap and wait until it is taken
    task automatic send_item(logic [1:0] code, logic pres, logic rd_bit, logic rd_cmp);
        int    gap;
        item_t it;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= code;
        presence_seen <= pres;
        id_bit        <= rd_bit;
        cmp_bit       <= rd_cmp;
        do @(posedge clk); while (in_stall !== 1'b0);
        it.op            = code;
        it.presence_seen = pres;
        it.id_bit        = rd_bit;
        it.cmp_bit       = rd_cmp;
        item_produced    = chk.note_input(it);
        if (item_produced)
            productive++;
    endtask

    // Stop sending and let every owed result come out
    task automatic drain();
        in_valid <= 1'b0;
        while (chk.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write the device limit, then read it back
    task automatic program_device_limit(logic [COUNT_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(REG_MAX_DEVICES));
        pwdata  <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== APB_DATA_W'(v))
        begin
            cfg_errors++;
            $display("device limit readback: expected %0d, got %h", v, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        chk.set_limit(v);
    endtask

    // Random transactions of any kind: stray bits, idle presences, unknown op
    task automatic noise_burst();
        int n;
        n = $urandom_range(5, 25);
        repeat (n)
            send_item(2'($urandom_range(0, 3)), rbit(), rbit(), rbit());
    endtask

    // One full search over a fresh random device population on the bus
    task automatic run_search();
        int                  ndev;
        int                  k;
        int                  pos;
        int                  r;
        logic                rd_bit;
        logic                rd_cmp;
        logic [ROM_ID_W-1:0] base;
        ndev = ($urandom_range(0, 9) == 0) ? 0 :
               ($urandom_range(0, 7) == 0) ? $urandom_range(4, MAX_BUS_DEV) :
               $urandom_range(1, 3);
        base = {$urandom, $urandom};
        for (k = 0; k < MAX_BUS_DEV; k++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                bus_ids[k] = '0;
            else if (r == 1)
                bus_ids[k] = '1;
            else if (r < 11)
                // near neighbors of a common code give deep branch points
                bus_ids[k] = base ^ (64'd1 << $urandom_range(0, 63))
                                  ^ (64'd1 << $urandom_range(32, 63));
            else
                bus_ids[k] = {$urandom, $urandom};
        end
        searches++;
        send_item(OP_START, rbit(), rbit(), rbit());
        while (chk.active)
        begin
            send_item(OP_PRESENCE, (ndev != 0) ^ ($urandom_range(0, 49) == 0),
                      rbit(), rbit());
            for (k = 0; k < MAX_BUS_DEV; k++)
                bus_alive[k] = (k < ndev);
            while (chk.active && chk.bits_left != 0)
            begin
                r = $urandom_range(0, 299);
                if (r == 0)
                begin
                    // bus reset in mid-pass restarts the pass
                    send_item(OP_PRESENCE, 1'b1, rbit(), rbit());
                    for (k = 0; k < MAX_BUS_DEV; k++)
                        bus_alive[k] = (k < ndev);
                end
                else if (r == 1)
                    send_item(OP_START, rbit(), rbit(), rbit());
                else
                begin
                    // wired-AND of the remaining devices' bit and its complement
                    pos    = ROM_BITS_DEF - int'(chk.bits_left);
                    rd_bit = 1'b1;
                    rd_cmp = 1'b1;
                    for (k = 0; k < MAX_BUS_DEV; k++)
                        if (bus_alive[k])
                        begin
                            rd_bit &= bus_ids[k][pos];
                            rd_cmp &= ~bus_ids[k][pos];
                        end
                    if (r < 5)
                    begin
                        rd_bit = rbit();
                        rd_cmp = rbit();
                    end
                    send_item(OP_BITS, rbit(), rd_bit, rd_cmp);
                    if (item_produced)
                        for (k = 0; k < MAX_BUS_DEV; k++)
                            if (bus_alive[k] && bus_ids[k][pos] != chk.last_wb)
                                bus_alive[k] = 1'b0;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        logic [COUNT_W-1:0] limits[NPHASE];
        int                 budget[NPHASE];
        int                 p;
        int                 target;
        chk = new();
        chk.power_on();
        productive = 0;
        searches   = 0;
        cfg_errors = 0;
        no_idle    = 1'b0;
        limits = '{8'd8, 8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(4, 254)), 8'd2};
        budget = '{320, 300, 420, 40, 300, 320, 250};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored items, no presence, data error, branch choice, restart
        send_item(OP_PRESENCE, 1'b1, 1'b1, 1'b1);
        send_item(OP_BITS, 1'b0, 1'b0, 1'b0);
        send_item(2'd3, 1'b1, 1'b1, 1'b1);
        send_item(OP_START, 1'b0, 1'b0, 1'b0);
        send_item(OP_BITS, 1'b1, 1'b1, 1'b0);
        send_item(OP_PRESENCE, 1'b0, 1'b1, 1'b1);
        send_item(OP_START, 1'b1, 1'b1, 1'b1);
        send_item(OP_PRESENCE, 1'b1, 1'b0, 1'b0);
        send_item(OP_BITS, 1'b0, 1'b1, 1'b1);
        send_item(OP_BITS, 1'b0, 1'b0, 1'b1);
        send_item(OP_START, 1'b0, 1'b0, 1'b0);
        send_item(OP_PRESENCE, 1'b1, 1'b0, 1'b0);
        send_item(OP_BITS, 1'b0, 1'b0, 1'b0);
        send_item(OP_BITS, 1'b1, 1'b1, 1'b0);
        send_item(OP_BITS, 1'b0, 1'b0, 1'b1);
        send_item(OP_BITS, 1'b0, 1'b0, 1'b0);
        send_item(OP_PRESENCE, 1'b1, 1'b1, 1'b1);
        send_item(OP_BITS, 1'b1, 1'b0, 1'b1);
        send_item(2'd3, 1'b0, 1'b0, 1'b0);
        send_item(OP_START, 1'b0, 1'b0, 1'b0);

        // random phases, one per device limit setting
        for (p = 0; p < NPHASE; p++)
        begin
            if (p > 0)
            begin
                drain();
                program_device_limit(limits[p]);
            end
            target = productive + budget[p];
            while (productive < target)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 6) == 0)
                    noise_burst();
                else
                    run_search();
            end
        end
        drain();

        $display("Ran %0d searches under device limits 8, 1, 255, 0, 3, %0d and 2;",
                 searches, limits[5]);
        $display("checked %0d results, %0d of them reporting a ROM ID, %0d mismatches.",
                 chk.checked, chk.ids_reported, chk.mismatches + cfg_errors);
        if (chk.mismatches == 0 && cfg_errors == 0 && chk.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
